### hdl/csvls_pkg.sv
// Shared types and constants for the CSV line field splitter.
// Holds the scan mode enum, the result struct and character codes.
// No dependencies.
package csvls_pkg;

    // Character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Register map and reset values
    localparam int          APB_ADDR_W        = 3;
    localparam logic        REG_FIELD_LIMIT   = 1'b0;
    localparam logic [7:0]  FIELD_LIMIT_RESET = 8'd8;

    // Default per-field buffer size (characters kept are one fewer)
    localparam int FIELD_BUFFER_SIZE_DEFAULT = 256;

    // Scanner mode
    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_PLAIN   = 3'd1,
        MODE_QUOTED  = 3'd2,
        MODE_QSEEN   = 3'd3,
        MODE_AFTER   = 3'd4
    } scan_mode_t;

    // One result item
    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic [7:0] field_index;
        logic [7:0] char_pos;
        logic       field_end;
        logic [7:0] field_length;
        logic       line_done;
        logic [7:0] field_count;
        logic       line_ok;
    } result_t;

endpackage

### hdl/csvls_apb_regs.sv
// APB configuration register file of the CSV line field splitter.
// Holds the field limit; depends on csvls_pkg.
module csvls_apb_regs
    import csvls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [7:0]            field_limit
);

    logic [7:0] field_limit_reg;
    logic       wr_en;

    // Write strobe on the access phase
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Field limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_limit_reg <= FIELD_LIMIT_RESET;
        end
        else if (wr_en && (paddr[2] == REG_FIELD_LIMIT))
        begin
            field_limit_reg <= pwdata[7:0];
        end
    end

    // Read mux
    always_comb
    begin
        unique case (paddr[2])
            REG_FIELD_LIMIT: prdata = {24'd0, field_limit_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign field_limit = field_limit_reg;

endmodule

### hdl/csvls_parser.sv
// Scanner of the CSV line field splitter: mode and counter registers plus
// the per-byte decode that forms one result item. Depends on csvls_pkg.
module csvls_parser
    import csvls_pkg::*;
#(
    parameter int FIELD_BUFFER_SIZE = FIELD_BUFFER_SIZE_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] line_byte,
    input  logic       line_end,
    input  logic [7:0] field_limit,
    output result_t    result
);

    // chars_reg plus one must stay below this to store one more character
    localparam logic [8:0] CHAR_LIMIT = 9'(FIELD_BUFFER_SIZE);

    scan_mode_t mode_reg, mode_next;
    logic [7:0] cur_field_reg, cur_field_next;
    logic [7:0] chars_reg, chars_next;

    logic       eol;
    logic       is_quote;
    logic       is_comma;
    logic       can_put;
    logic       do_put;
    logic       do_close;
    logic [7:0] put_value;
    logic [7:0] count_at_end;

    // Byte decode
    assign eol      = line_end || (line_byte == CH_NUL);
    assign is_quote = (line_byte == CH_QUOTE);
    assign is_comma = (line_byte == CH_COMMA);
    assign can_put  = (({1'b0, chars_reg} + 9'd1) < CHAR_LIMIT);

    // Next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (eol)
        begin
            mode_next = MODE_BETWEEN;
        end
        else
        begin
            unique case (mode_reg)
                MODE_BETWEEN:
                begin
                    if (cur_field_reg < field_limit)
                    begin
                        if (is_quote)
                            mode_next = MODE_QUOTED;
                        else if (is_comma)
                            mode_next = MODE_BETWEEN;
                        else
                            mode_next = MODE_PLAIN;
                    end
                end
                MODE_PLAIN:
                begin
                    if (is_comma)
                        mode_next = MODE_BETWEEN;
                end
                MODE_QUOTED:
                begin
                    if (is_quote)
                        mode_next = MODE_QSEEN;
                end
                MODE_QSEEN:
                begin
                    if (is_quote)
                        mode_next = MODE_QUOTED;
                    else if (is_comma)
                        mode_next = MODE_BETWEEN;
                    else
                        mode_next = MODE_AFTER;
                end
                default:
                begin
                    if (is_comma)
                        mode_next = MODE_BETWEEN;
                    else
                        mode_next = MODE_AFTER;
                end
            endcase
        end
    end

    // Actions of the current byte: store a character and/or close a field
    always_comb
    begin
        do_put    = 1'b0;
        do_close  = 1'b0;
        put_value = line_byte;
        if (eol)
        begin
            do_close = (mode_reg != MODE_BETWEEN);
        end
        else
        begin
            unique case (mode_reg)
                MODE_BETWEEN:
                begin
                    if (cur_field_reg < field_limit)
                    begin
                        do_close = is_comma;
                        do_put   = !is_comma && !is_quote;
                    end
                end
                MODE_PLAIN:
                begin
                    do_close = is_comma;
                    do_put   = !is_comma;
                end
                MODE_QUOTED:
                begin
                    do_put = !is_quote;
                end
                MODE_QSEEN:
                begin
                    do_close  = is_comma;
                    do_put    = is_quote;
                    put_value = CH_QUOTE;
                end
                default:
                begin
                    do_close = is_comma;
                end
            endcase
        end
    end

    // Result item
    assign count_at_end = cur_field_reg + {7'd0, do_close};

    always_comb
    begin
        result = '0;
        if (do_put && can_put)
        begin
            result.char_valid  = 1'b1;
            result.out_char    = put_value;
            result.field_index = cur_field_reg;
            result.char_pos    = chars_reg;
        end
        if (do_close)
        begin
            result.field_index  = cur_field_reg;
            result.field_end    = 1'b1;
            result.field_length = chars_reg;
        end
        if (eol)
        begin
            result.line_done   = 1'b1;
            result.field_count = count_at_end;
            result.line_ok     = (count_at_end != 8'd0);
        end
    end

    // Counter updates
    always_comb
    begin
        cur_field_next = cur_field_reg;
        chars_next     = chars_reg;
        if (eol)
        begin
            cur_field_next = 8'd0;
            chars_next     = 8'd0;
        end
        else if (do_close)
        begin
            cur_field_next = cur_field_reg + 8'd1;
            chars_next     = 8'd0;
        end
        else if (do_put && can_put)
        begin
            chars_next = chars_reg + 8'd1;
        end
    end

    // State registers, updated on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_BETWEEN;
            cur_field_reg <= 8'd0;
            chars_reg     <= 8'd0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            cur_field_reg <= cur_field_next;
            chars_reg     <= chars_next;
        end
    end

`ifndef SYNTHESIS
    a_between_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_BETWEEN) |-> (chars_reg == 8'd0))
        else $error("character count nonzero between fields");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && eol) |=> ((cur_field_reg == 8'd0) && (mode_reg == MODE_BETWEEN)))
        else $error("state not cleared after line end");

    a_char_fits: assert property (@(posedge clk) disable iff (!rst_n)
        result.char_valid |-> (({1'b0, chars_reg} + 9'd1) < CHAR_LIMIT))
        else $error("character delivered beyond field buffer");
`endif

endmodule

### hdl/csvls_out_skid.sv
// Output register with a skid entry for the result channel.
// Keeps the input side accepting while a result waits. Depends on csvls_pkg.
module csvls_out_skid
    import csvls_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            if (!out_valid_reg || out_ready)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
                out_data_reg <= skid_data_reg;
        end
        else if (in_valid)
        begin
            if (!out_valid_reg || out_ready)
                out_data_reg <= in_data;
            else
                skid_data_reg <= in_data;
        end
    end

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("stalled result dropped");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid entry not moved to output register");
`endif

endmodule

### hdl/csv_line_field_splitter.sv
// Top level of the CSV line field splitter: APB registers, byte scanner
// and output skid stage. Depends on csvls_pkg and the csvls_* modules.
//
// Usage:
//   Input stream: one line byte per request on s_tdata; s_tlast marks the
//   line end (a zero byte ends the line too). Output stream: one result per
//   input byte, carrying a delivered character, a field close and, with
//   m_tlast, the line end with the field count.
//   Registering: the result of a byte is held in the output register, or
//   in the skid entry while the output is stalled. Throughput: one byte per
//   cycle while s_tready is high, the scanner updating on each accepted byte.
//   Stall: when m_tready is low, the output register and one skid entry
//   hold two results; s_tready drops only once both are full, and rises
//   again the cycle after the receiver takes one.
//   Reset: scan state returns to between fields with zero counts and
//   the field limit to 8; no clearing pass, bytes are taken right after reset.
//   Config: field limit at byte address 0; the user must write it only while idle, the block does not enforce this.
module csv_line_field_splitter
    import csvls_pkg::*;
#(
    parameter int FIELD_BUFFER_SIZE = FIELD_BUFFER_SIZE_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] line_byte
    input  logic                  s_tlast,   // line_end
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // [7:0] out_char, [15:8] field_index,
                                             // [23:16] char_pos, [31:24] field_length,
                                             // [39:32] field_count
    output logic [2:0]            m_tuser,   // [0] char_valid, [1] field_end, [2] line_ok
    output logic                  m_tlast    // line_done
);

    logic [7:0] field_limit;
    logic       accept;
    result_t    parse_res;
    result_t    out_res;

    // Configuration registers
    csvls_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .field_limit (field_limit)
    );

    assign accept = s_tvalid && s_tready;

    // Byte scanner
    csvls_parser #(
        .FIELD_BUFFER_SIZE (FIELD_BUFFER_SIZE)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .line_byte   (s_tdata),
        .line_end    (s_tlast),
        .field_limit (field_limit),
        .result      (parse_res)
    );

    // Output register and skid entry
    csvls_out_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (parse_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Port packing
    assign m_tdata = {out_res.field_count, out_res.field_length, out_res.char_pos,
                      out_res.field_index, out_res.out_char};
    assign m_tuser = {out_res.line_ok, out_res.field_end, out_res.char_valid};
    assign m_tlast = out_res.line_done;

endmodule

### verif/csvls_line_checker_pkg.sv
// Line checker for the CSV line field splitter testbench: predicts the
// result of each accepted byte request and matches the results in order.
// Depends on csvls_pkg.
package csvls_line_checker_pkg;

    import csvls_pkg::*;

    class line_split_checker;

        // Scanner state as the block should hold it
        scan_mode_t mode;
        logic [7:0] field_no;
        logic [7:0] field_chars;
        logic [7:0] field_limit;

        result_t    next_result;
        result_t    results_due[$];
        int         errors;

        function new();
            mode        = MODE_BETWEEN;
            field_no    = 8'd0;
            field_chars = 8'd0;
            field_limit = FIELD_LIMIT_RESET;
            errors      = 0;
        endfunction

        function void set_field_limit(logic [7:0] value);
            field_limit = value;
        endfunction

        function int outstanding();
            return results_due.size();
        endfunction

        // Count a failure; only the first ten are printed
        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function string show(result_t r);
            return $sformatf("cv=%0b ch=%02h fi=%0d pos=%0d end=%0b len=%0d done=%0b cnt=%0d ok=%0b",
                             r.char_valid, r.out_char, r.field_index, r.char_pos, r.field_end,
                             r.field_length, r.line_done, r.field_count, r.line_ok);
        endfunction

        // Store one character unless the field buffer is full
        function void store_char(logic [7:0] c);
            if (int'(field_chars) + 1 < FIELD_BUFFER_SIZE_DEFAULT)
            begin
                next_result.char_valid  = 1'b1;
                next_result.out_char    = c;
                next_result.field_index = field_no;
                next_result.char_pos    = field_chars;
                field_chars             = field_chars + 8'd1;
            end
        endfunction

        function void close_field();
            next_result.field_index  = field_no;
            next_result.field_end    = 1'b1;
            next_result.field_length = field_chars;
            field_no    = field_no + 8'd1;
            field_chars = 8'd0;
            mode        = MODE_BETWEEN;
        endfunction

        // Accepted byte request: work out its result and queue it
        function void take_byte(logic [7:0] b, logic line_end);
            next_result = '0;
            if (line_end || b == CH_NUL)
            begin
                if (mode != MODE_BETWEEN)
                    close_field();
                next_result.line_done   = 1'b1;
                next_result.field_count = field_no;
                next_result.line_ok     = (field_no != 8'd0);
                mode        = MODE_BETWEEN;
                field_no    = 8'd0;
                field_chars = 8'd0;
            end
            else
            begin
                case (mode)
                    MODE_BETWEEN:
                    begin
                        // no field opens once the limit is reached
                        if (field_no < field_limit)
                        begin
                            field_chars = 8'd0;
                            if (b == CH_QUOTE)
                                mode = MODE_QUOTED;
                            else if (b == CH_COMMA)
                                close_field();
                            else
                            begin
                                mode = MODE_PLAIN;
                                store_char(b);
                            end
                        end
                    end
                    MODE_PLAIN:
                    begin
                        if (b == CH_COMMA)
                            close_field();
                        else
                            store_char(b);
                    end
                    MODE_QUOTED:
                    begin
                        if (b == CH_QUOTE)
                            mode = MODE_QSEEN;
                        else
                            store_char(b);
                    end
                    MODE_QSEEN:
                    begin
                        // doubled quote, close on comma, else junk follows
                        if (b == CH_QUOTE)
                        begin
                            mode = MODE_QUOTED;
                            store_char(CH_QUOTE);
                        end
                        else if (b == CH_COMMA)
                            close_field();
                        else
                            mode = MODE_AFTER;
                    end
                    default:
                    begin
                        if (b == CH_COMMA)
                            close_field();
                        else
                            mode = MODE_AFTER;
                    end
                endcase
            end
            results_due.push_back(next_result);
        endfunction

        // Match one accepted result against the oldest expectation
        function void match_result(result_t got);
            result_t want;
            if (results_due.size() == 0)
                flag({"unexpected result: ", show(got)});
            else
            begin
                want = results_due.pop_front();
                if (got !== want)
                    flag({"mismatch: expected ", show(want), " got ", show(got)});
            end
        endfunction

    endclass

endpackage

### verif/tb_csv_line_field_splitter.sv
// Testbench for csv_line_field_splitter: directed and random lines with
// random gaps on both streams, APB limit writes between phases.
// Depends on csvls_pkg, csvls_line_checker_pkg and the splitter RTL.
module tb_csv_line_field_splitter;

    import csvls_pkg::*;
    import csvls_line_checker_pkg::*;

    localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = APB_ADDR_W'(4 * REG_FIELD_LIMIT);
    localparam int QUIET_LIMIT = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;
    logic [2:0]            m_tuser;
    logic                  m_tlast;

    line_split_checker chk;
    int   bytes_sent;
    int   quiet_cycles;
    int   ready_run;
    int   stall_run;
    bit   steady;
    bit   paused;
    logic [7:0] limits [5];

    csv_line_field_splitter #(.FIELD_BUFFER_SIZE(FIELD_BUFFER_SIZE_DEFAULT)) dut (.*);

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Any byte that neither ends the line nor cuts or quotes a field
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_COMMA || c == CH_QUOTE);
        return c;
    endfunction

    function automatic int field_len();
        if ($urandom_range(0, 99) < 2)
            return $urandom_range(250, 300);
        return $urandom_range(0, 6);
    endfunction

    // Receiver stalls
    always @(negedge clk)
    begin
        if (steady)
            m_tready <= 1'b1;
        else if (m_tready)
        begin
            if (ready_run > 0)
                ready_run--;
            else
            begin
                stall_run = pick_gap();
                if (stall_run > 0)
                    m_tready <= 1'b0;
                else
                    ready_run = $urandom_range(0, 8);
            end
        end
        else if (stall_run > 1)
            stall_run--;
        else
        begin
            m_tready <= 1'b1;
            ready_run = $urandom_range(0, 8);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            chk.match_result('{char_valid:   m_tuser[0],
                               out_char:     m_tdata[7:0],
                               field_index:  m_tdata[15:8],
                               char_pos:     m_tdata[23:16],
                               field_end:    m_tuser[1],
                               field_length: m_tdata[31:24],
                               line_done:    m_tlast,
                               field_count:  m_tdata[39:32],
                               line_ok:      m_tuser[2]});
    end

    // Watchdog on cycles with no accepted byte, no taken result and no APB select
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // One byte request; called and left at a falling edge
    task automatic send_byte(logic [7:0] b, logic line_end);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= line_end;
        do
            @(posedge clk);
        while (!s_tready);
        chk.take_byte(b, line_end);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_plain(int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            // a quote past the first byte is a plain character
            if (i > 0 && $urandom_range(0, 19) == 0)
                send_byte(CH_QUOTE, 1'b0);
            else
                send_byte(text_char(), 1'b0);
        end
    endtask

    task automatic send_quoted(int n, bit closed, bit junk);
        int i;
        int r;
        send_byte(CH_QUOTE, 1'b0);
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                send_byte(CH_COMMA, 1'b0);
            else if (r < 18)
            begin
                send_byte(CH_QUOTE, 1'b0);
                send_byte(CH_QUOTE, 1'b0);
            end
            else
                send_byte(text_char(), 1'b0);
        end
        if (closed)
        begin
            send_byte(CH_QUOTE, 1'b0);
            // bytes after the closing quote are dropped
            if (junk)
            begin
                send_byte(text_char(), 1'b0);
                repeat ($urandom_range(0, 2))
                    send_byte($urandom_range(0, 1) ? CH_QUOTE : text_char(), 1'b0);
            end
        end
    endtask

    // Line end by tlast with a random byte, or by a zero byte
    task automatic end_line();
        if ($urandom_range(0, 6) == 0)
            send_byte(CH_NUL, 1'b0);
        else
            send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // One random line: mostly well formed, some noise and comma runs
    task automatic send_line(logic [7:0] limit);
        int kind;
        int nf;
        int f;
        int r;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            repeat ($urandom_range(0, 16))
            begin
                r = $urandom_range(0, 9);
                if (r < 3)
                    send_byte(CH_COMMA, 1'b0);
                else if (r < 5)
                    send_byte(CH_QUOTE, 1'b0);
                else
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        else if (kind < 11)
        begin
            repeat ($urandom_range(0, int'(limit) + 3))
                send_byte(CH_COMMA, 1'b0);
        end
        else
        begin
            nf = $urandom_range(0, (limit < 6 ? int'(limit) : 6) + 2);
            for (f = 0; f < nf; f++)
            begin
                if (f > 0)
                    send_byte(CH_COMMA, 1'b0);
                if ($urandom_range(0, 9) < 3)
                    send_quoted(field_len(),
                                !(f == nf - 1 && $urandom_range(0, 9) == 0),
                                $urandom_range(0, 4) == 0);
                else
                    send_plain(field_len());
            end
            if ($urandom_range(0, 9) == 0)
                send_byte(CH_COMMA, 1'b0);
        end
        end_line();
    endtask

    // Hold the sender until every expected result has come
    task automatic wait_results_clear();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (chk.outstanding() != 0);
    endtask

    // Write the field limit while idle, then read it back
    task automatic set_limit(logic [7:0] value);
        wait_results_clear();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        chk.set_field_limit(value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[7:0] !== value)
            chk.flag($sformatf("field limit read back: expected %0d got %0d",
                               value, prdata[7:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        int p;
        int phase_end;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'd0;
        s_tlast    = 1'b0;
        m_tready   = 1'b1;
        steady     = 1'b0;
        ready_run  = 0;
        stall_run  = 0;
        bytes_sent = 0;
        quiet_cycles = 0;
        chk = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: plain, quoted with doubled quote and literal comma,
        // junk after the closing quote, empty field, trailing comma
        send_text("a,\"b\"\",c\"x,,");
        send_byte(8'hFF, 1'b1);
        // quote just before a zero byte line end
        send_text("\"q\"");
        send_byte(CH_NUL, 1'b0);
        // empty line, then extreme byte values
        send_byte(8'h5A, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b1);
        // single field limit
        set_limit(8'd1);
        send_text("a,b");
        send_byte(CH_NUL, 1'b1);
        // limit lowered in the middle of a line
        set_limit(8'd8);
        send_text("a,b,");
        set_limit(8'd1);
        send_text("c");
        send_byte(CH_COMMA, 1'b1);
        // overlong plain and quoted fields
        set_limit(8'd8);
        send_plain(258);
        send_byte(CH_COMMA, 1'b0);
        send_quoted(258, 1'b1, 1'b0);
        send_byte(8'h00, 1'b1);

        // Random phases over several limits
        limits[0] = 8'd1;
        limits[1] = 8'd255;
        limits[2] = 8'd3;
        limits[3] = 8'd8;
        limits[4] = 8'($urandom_range(1, 255));
        for (p = 0; p < 5; p++)
        begin
            set_limit(limits[p]);
            phase_end = bytes_sent + 180;
            paused    = 1'b0;
            // more fields than the widest limit allows
            if (limits[p] == 8'd255)
            begin
                repeat (257)
                    send_byte(CH_COMMA, 1'b0);
                send_byte(8'hA5, 1'b1);
            end
            while (bytes_sent < phase_end)
            begin
                steady = ($urandom_range(0, 9) == 0);
                send_line(limits[p]);
                if (!paused && bytes_sent > phase_end - 90)
                begin
                    wait_results_clear();
                    paused = 1'b1;
                end
            end
        end
        steady = 1'b0;

        wait_results_clear();
        repeat (8) @(posedge clk);
        if (chk.errors == 0 && chk.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
hdl/csvls_pkg.sv
hdl/csvls_apb_regs.sv
hdl/csvls_parser.sv
hdl/csvls_out_skid.sv
hdl/csv_line_field_splitter.sv
verif/csvls_line_checker_pkg.sv
verif/tb_csv_line_field_splitter.sv
